// File: hdl/accel_tilt_angles_assert.svh
// Assertion macros shared by the tilt angle checker.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define TILT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define TILT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tilt_pkg.sv
// Shared widths, constants, types and the arctangent table of the tilt angle pipeline.
`timescale 1ns / 1ps

package tilt_pkg;

  localparam int ACCEL_W     = 16;
  localparam int ROLL_W      = 16;
  localparam int PITCH_W     = 15;
  localparam int ANGLE_W     = 16;

  // Square root of (y*y + z*z) * 2^32, one result bit per stage.
  localparam int SQ_W        = 32;
  localparam int REM_W       = 2 * SQ_W;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = 32;

  // CORDIC datapath.
  localparam int IN_W        = 34;
  localparam int VEC_W       = 42;
  localparam int NORM_W      = 39;
  localparam int NORM_STAGES = 3;
  localparam int Z_W         = 33;
  localparam int MAG_W       = 32;
  localparam int SCALE_W     = 13;
  localparam int PROD_W      = 45;
  localparam int ROUND_SHIFT = 30;
  localparam int ATAN_IDX_W  = 5;

  localparam logic [SCALE_W-1:0]    DEG_SCALE   = 13'd5730;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

  typedef struct packed {
    logic enable;
    logic valid;
  } pipe_ctl_t;

  // Arctangent of 2^-i in radians, Q30, truncated.
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 33'sd843314856;
      5'd1:    val = 33'sd497837829;
      5'd2:    val = 33'sd263043836;
      5'd3:    val = 33'sd133525158;
      5'd4:    val = 33'sd67021686;
      5'd5:    val = 33'sd33543515;
      5'd6:    val = 33'sd16775850;
      5'd7:    val = 33'sd8388437;
      5'd8:    val = 33'sd4194282;
      5'd9:    val = 33'sd2097149;
      5'd10:   val = 33'sd1048575;
      5'd11:   val = 33'sd524287;
      5'd12:   val = 33'sd262143;
      5'd13:   val = 33'sd131071;
      5'd14:   val = 33'sd65535;
      5'd15:   val = 33'sd32767;
      5'd16:   val = 33'sd16383;
      5'd17:   val = 33'sd8191;
      5'd18:   val = 33'sd4095;
      5'd19:   val = 33'sd2047;
      5'd20:   val = 33'sd1023;
      5'd21:   val = 33'sd511;
      5'd22:   val = 33'sd255;
      5'd23:   val = 33'sd127;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/tilt_sample_if.sv
// Request channel carrying one raw accelerometer sample.
`timescale 1ns / 1ps

interface tilt_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [tilt_pkg::ACCEL_W-1:0] accel_x;
  logic signed [tilt_pkg::ACCEL_W-1:0] accel_y;
  logic signed [tilt_pkg::ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

// File: hdl/tilt_angle_if.sv
// Request channel carrying one roll and pitch result.
`timescale 1ns / 1ps

interface tilt_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [tilt_pkg::ROLL_W-1:0]  roll_centideg;
  logic signed [tilt_pkg::PITCH_W-1:0] pitch_centideg;

  modport source (output valid, output roll_centideg, output pitch_centideg,
                  input ready);
  modport sink (input valid, input roll_centideg, input pitch_centideg,
                output ready);
endinterface

// File: hdl/tilt_sqrt.sv
// Pipelined squares, sum and bit-per-stage square root of the y/z magnitude.
`timescale 1ns / 1ps

module tilt_sqrt (
  input  logic                                clk,
  input  logic                                rst,
  input  tilt_pkg::pipe_ctl_t                 ctl,
  input  logic signed [tilt_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [tilt_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [tilt_pkg::ACCEL_W-1:0] accel_z,
  output logic                                valid,
  output logic [tilt_pkg::ROOT_W-1:0]         root,
  output logic signed [tilt_pkg::ACCEL_W-1:0] x,
  output logic signed [tilt_pkg::ACCEL_W-1:0] y,
  output logic signed [tilt_pkg::ACCEL_W-1:0] z
);

  localparam int STEPS = tilt_pkg::SQRT_STEPS;
  localparam int SQ_W  = tilt_pkg::SQ_W;
  localparam int REM_W = tilt_pkg::REM_W;
  localparam int AW    = tilt_pkg::ACCEL_W;

  logic signed [SQ_W-1:0] ysq_w;
  logic signed [SQ_W-1:0] zsq_w;

  logic                   sq_valid;
  logic [SQ_W-1:0]        ysq;
  logic [SQ_W-1:0]        zsq;
  logic signed [AW-1:0]   sq_x;
  logic signed [AW-1:0]   sq_y;
  logic signed [AW-1:0]   sq_z;

  logic                   v_p   [STEPS+1];
  logic [REM_W-1:0]       rem_p [STEPS+1];
  logic [REM_W-1:0]       root_p[STEPS+1];
  logic signed [AW-1:0]   x_p   [STEPS+1];
  logic signed [AW-1:0]   y_p   [STEPS+1];
  logic signed [AW-1:0]   z_p   [STEPS+1];

  assign ysq_w = accel_y * accel_y;
  assign zsq_w = accel_z * accel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      v_p[0]   <= 1'b0;
    end else if (ctl.enable) begin
      sq_valid <= ctl.valid;
      v_p[0]   <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enable) begin
      ysq       <= unsigned'(ysq_w);
      zsq       <= unsigned'(zsq_w);
      sq_x      <= accel_x;
      sq_y      <= accel_y;
      sq_z      <= accel_z;
      // Both squares are at most 2^30, so the sum fits without a carry.
      rem_p[0]  <= {ysq + zsq, {SQ_W{1'b0}}};
      root_p[0] <= '0;
      x_p[0]    <= sq_x;
      y_p[0]    <= sq_y;
      z_p[0]    <= sq_z;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_root
    localparam logic [REM_W-1:0] BIT = REM_W'(1) << (REM_W - 2 - 2 * k);

    logic [REM_W-1:0] trial;
    logic             fits;

    assign trial = root_p[k] + BIT;
    assign fits  = rem_p[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k+1] <= 1'b0;
      end else if (ctl.enable) begin
        v_p[k+1] <= v_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.enable) begin
        if (fits) begin
          rem_p[k+1]  <= rem_p[k] - trial;
          root_p[k+1] <= (root_p[k] >> 1) + BIT;
        end else begin
          rem_p[k+1]  <= rem_p[k];
          root_p[k+1] <= root_p[k] >> 1;
        end
        x_p[k+1] <= x_p[k];
        y_p[k+1] <= y_p[k];
        z_p[k+1] <= z_p[k];
      end
    end
  end

  assign valid = v_p[STEPS];
  assign root  = root_p[STEPS][tilt_pkg::ROOT_W-1:0];
  assign x     = x_p[STEPS];
  assign y     = y_p[STEPS];
  assign z     = z_p[STEPS];

endmodule

// File: hdl/tilt_atan2.sv
// Pipelined atan2 by vectoring CORDIC, scaled to rounded hundredths of a degree.
`timescale 1ns / 1ps

module tilt_atan2 #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tilt_pkg::pipe_ctl_t                 ctl,
  input  logic signed [tilt_pkg::IN_W-1:0]    yi,
  input  logic signed [tilt_pkg::IN_W-1:0]    xi,
  output logic                                valid,
  output logic signed [tilt_pkg::ANGLE_W-1:0] angle
);

  localparam int VEC_W  = tilt_pkg::VEC_W;
  localparam int NORM_W = tilt_pkg::NORM_W;
  localparam int NS     = tilt_pkg::NORM_STAGES;
  localparam int Z_W    = tilt_pkg::Z_W;
  localparam int MAG_W  = tilt_pkg::MAG_W;
  localparam int PROD_W = tilt_pkg::PROD_W;
  localparam int RS     = tilt_pkg::ROUND_SHIFT;
  localparam int AW     = tilt_pkg::ANGLE_W;
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (RS - 1);

  logic signed [VEC_W-1:0] xe;
  logic signed [VEC_W-1:0] ye;
  logic signed [VEC_W-1:0] rx;
  logic signed [VEC_W-1:0] ry;
  logic signed [VEC_W-1:0] ry_abs;
  logic signed [Z_W-1:0]   rz;

  // Normalizer stages; entry 0 holds the quadrant-corrected vector.
  logic                    n_v   [NS+1];
  logic                    n_zero[NS+1];
  logic signed [VEC_W-1:0] n_x   [NS+1];
  logic signed [VEC_W-1:0] n_y   [NS+1];
  logic signed [Z_W-1:0]   n_z   [NS+1];
  logic [NORM_W-1:0]       n_m   [NS+1];

  // CORDIC stages; entry 0 is the normalizer output.
  logic                    c_v   [CORDIC_STEPS+1];
  logic                    c_zero[CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] c_x   [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] c_y   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]   c_z   [CORDIC_STEPS+1];

  logic                    abs_valid;
  logic                    abs_sign;
  logic [MAG_W-1:0]        abs_mag;
  logic signed [Z_W-1:0]   z_abs;

  logic                    mul_valid;
  logic                    mul_sign;
  logic [PROD_W-1:0]       mul_prod;
  logic [PROD_W-1:0]       prod_w;

  logic                    out_valid;
  logic signed [AW-1:0]    out_angle;
  logic [PROD_W-1:0]       rounded;
  logic signed [AW-1:0]    mag_s;

  assign xe = VEC_W'(xi);
  assign ye = VEC_W'(yi);

  // A vector in the left half plane is turned by a quarter turn first.
  always_comb begin
    rx = xe;
    ry = ye;
    rz = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        rx = ye;
        ry = -xe;
        rz = tilt_pkg::HALF_PI_Q30;
      end else begin
        rx = -ye;
        ry = xe;
        rz = -tilt_pkg::HALF_PI_Q30;
      end
    end
    ry_abs = (ry < 0) ? -ry : ry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v[0] <= 1'b0;
    end else if (ctl.enable) begin
      n_v[0] <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enable) begin
      n_zero[0] <= (xi == '0) && (yi == '0);
      n_x[0]    <= rx;
      n_y[0]    <= ry;
      n_z[0]    <= rz;
      n_m[0]    <= rx[NORM_W-1:0] | ry_abs[NORM_W-1:0];
    end
  end

  // Each stage tries two shift widths, so the shift sets 32/16, 8/4, 2/1.
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int KA = 1 << (2 * (NS - 1 - j) + 1);
    localparam int KB = KA / 2;

    logic [NORM_W-1:0]       t_m;
    logic signed [VEC_W-1:0] t_x;
    logic signed [VEC_W-1:0] t_y;

    always_comb begin
      t_m = n_m[j];
      t_x = n_x[j];
      t_y = n_y[j];
      if (t_m[NORM_W-1 -: KA] == '0) begin
        t_m = t_m << KA;
        t_x = t_x <<< KA;
        t_y = t_y <<< KA;
      end
      if (t_m[NORM_W-1 -: KB] == '0) begin
        t_m = t_m << KB;
        t_x = t_x <<< KB;
        t_y = t_y <<< KB;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        n_v[j+1] <= 1'b0;
      end else if (ctl.enable) begin
        n_v[j+1] <= n_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.enable) begin
        n_zero[j+1] <= n_zero[j];
        n_x[j+1]    <= t_x;
        n_y[j+1]    <= t_y;
        n_z[j+1]    <= n_z[j];
        n_m[j+1]    <= t_m;
      end
    end
  end

  assign c_v[0]    = n_v[NS];
  assign c_zero[0] = n_zero[NS];
  assign c_x[0]    = n_x[NS];
  assign c_y[0]    = n_y[NS];
  assign c_z[0]    = n_z[NS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN_I =
      tilt_pkg::atan_q30(tilt_pkg::ATAN_IDX_W'(i));

    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    assign dx = c_y[i] >>> i;
    assign dy = c_x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[i+1] <= 1'b0;
      end else if (ctl.enable) begin
        c_v[i+1] <= c_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.enable) begin
        c_zero[i+1] <= c_zero[i];
        if (c_y[i] > 0) begin
          c_x[i+1] <= c_x[i] + dx;
          c_y[i+1] <= c_y[i] - dy;
          c_z[i+1] <= c_z[i] + ATAN_I;
        end else begin
          c_x[i+1] <= c_x[i] - dx;
          c_y[i+1] <= c_y[i] + dy;
          c_z[i+1] <= c_z[i] - ATAN_I;
        end
      end
    end
  end

  assign z_abs   = (c_z[CORDIC_STEPS] < 0) ? -c_z[CORDIC_STEPS] : c_z[CORDIC_STEPS];
  assign prod_w  = abs_mag * tilt_pkg::DEG_SCALE;
  assign rounded = mul_prod + ROUND_BIAS;
  assign mag_s   = signed'({1'b0, rounded[PROD_W-1:RS]});

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid <= 1'b0;
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.enable) begin
      abs_valid <= c_v[CORDIC_STEPS];
      mul_valid <= abs_valid;
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enable) begin
      // A zero vector has no direction and reports an angle of zero.
      abs_sign  <= c_z[CORDIC_STEPS] < 0;
      abs_mag   <= c_zero[CORDIC_STEPS] ? '0 : z_abs[MAG_W-1:0];
      mul_sign  <= abs_sign;
      mul_prod  <= prod_w;
      out_angle <= mul_sign ? -mag_s : mag_s;
    end
  end

  assign valid = out_valid;
  assign angle = out_angle;

endmodule

// File: hdl/accel_tilt_angles.sv
// Roll and pitch of a raw accelerometer sample, one sample accepted per cycle.
// Stages: 2 for squares and sum, 32 root stages, 1 quadrant stage, 3 normalize stages,
// one per CORDIC step, 3 scale stages, output.
// Throughput is one sample per cycle; ready falls only in reset or while a result waits
// at the output and another has reached the last stage. Synchronous reset clears all valid bits.
`timescale 1ns / 1ps

module accel_tilt_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  tilt_sample_if.sink   sample,
  tilt_angle_if.source  angle
);

  localparam int AW   = tilt_pkg::ACCEL_W;
  localparam int IN_W = tilt_pkg::IN_W;

  logic                         enable;
  logic                         accept;
  tilt_pkg::pipe_ctl_t          sqrt_ctl;
  tilt_pkg::pipe_ctl_t          atan_ctl;

  logic                         sqrt_valid;
  logic [tilt_pkg::ROOT_W-1:0]  sqrt_root;
  logic signed [AW-1:0]         sq_x;
  logic signed [AW-1:0]         sq_y;
  logic signed [AW-1:0]         sq_z;

  logic [AW+1:0]                neg_x;
  logic signed [IN_W-1:0]       roll_yi;
  logic signed [IN_W-1:0]       roll_xi;
  logic signed [IN_W-1:0]       pitch_yi;
  logic signed [IN_W-1:0]       pitch_xi;

  logic                         roll_valid;
  logic                         pitch_valid;
  logic                         last_valid;
  logic signed [tilt_pkg::ANGLE_W-1:0] roll_angle;
  logic signed [tilt_pkg::ANGLE_W-1:0] pitch_angle;

  logic                         out_valid;
  logic signed [tilt_pkg::ROLL_W-1:0]  out_roll;
  logic signed [tilt_pkg::PITCH_W-1:0] out_pitch;

  // The whole pipeline moves unless a finished result is blocked at the output and another waits in the last stage.
  assign enable       = !last_valid || !out_valid || angle.ready;
  assign sample.ready = enable && !rst;
  assign accept       = sample.valid && sample.ready;

  assign sqrt_ctl = '{enable: enable, valid: accept};
  assign atan_ctl = '{enable: enable, valid: sqrt_valid};

  tilt_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sqrt_ctl),
    .accel_x (sample.accel_x),
    .accel_y (sample.accel_y),
    .accel_z (sample.accel_z),
    .valid   (sqrt_valid),
    .root    (sqrt_root),
    .x       (sq_x),
    .y       (sq_y),
    .z       (sq_z)
  );

  // Pitch numerator is -x scaled by 2^16 to match the Q16 magnitude.
  assign neg_x    = -{{2{sq_x[AW-1]}}, sq_x};
  assign roll_yi  = {{(IN_W - AW){sq_y[AW-1]}}, sq_y};
  assign roll_xi  = {{(IN_W - AW){sq_z[AW-1]}}, sq_z};
  assign pitch_yi = signed'({neg_x, {AW{1'b0}}});
  assign pitch_xi = signed'({{(IN_W - tilt_pkg::ROOT_W){1'b0}}, sqrt_root});

  tilt_atan2 #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_roll (
    .clk   (clk),
    .rst   (rst),
    .ctl   (atan_ctl),
    .yi    (roll_yi),
    .xi    (roll_xi),
    .valid (roll_valid),
    .angle (roll_angle)
  );

  tilt_atan2 #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_pitch (
    .clk   (clk),
    .rst   (rst),
    .ctl   (atan_ctl),
    .yi    (pitch_yi),
    .xi    (pitch_xi),
    .valid (pitch_valid),
    .angle (pitch_angle)
  );

  assign last_valid = roll_valid && pitch_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable && last_valid) begin
      out_valid <= 1'b1;
    end else if (angle.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enable && last_valid) begin
      out_roll  <= roll_angle;
      out_pitch <= pitch_angle[tilt_pkg::PITCH_W-1:0];
    end
  end

  assign angle.valid          = out_valid;
  assign angle.roll_centideg  = out_roll;
  assign angle.pitch_centideg = out_pitch;

endmodule

// File: hdl/tilt_checker.sv
// Port-level checks of the tilt angle block, bound to its top level.
`timescale 1ns / 1ps
`include "accel_tilt_angles_assert.svh"

module tilt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tilt_pkg::ROLL_W-1:0]  roll,
  input logic signed [tilt_pkg::PITCH_W-1:0] pitch
);

  logic       in_acc;
  logic       out_acc;
  logic [7:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests taken in and not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + 8'd1;
    end else if (out_acc && !in_acc) begin
      inflight <= inflight - 8'd1;
    end
  end

  `TILT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")
  `TILT_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(roll) && $stable(pitch), "stalled result changed")
  `TILT_ASSERT(a_ready_free, clk, rst, !out_valid || out_ready |-> in_ready, "input stalled with free output")
  `TILT_ASSERT(a_no_invent, clk, rst, out_valid |-> inflight != 8'd0, "result without a request")

endmodule

bind accel_tilt_angles tilt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (angle.valid),
  .out_ready (angle.ready),
  .roll      (angle.roll_centideg),
  .pitch     (angle.pitch_centideg)
);

// File: test/tb_accel_tilt_angles.sv
// Self-checking testbench for the accelerometer roll and pitch pipeline.
`timescale 1ns / 1ps

module tb_accel_tilt_angles;

  localparam int  STEPS       = 16;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN       = 120;
  localparam int  N_RANDOM    = 700;
  localparam longint NORM_LIMIT  = 64'sd1 << 38;
  localparam longint HALF_PI_RAD = 64'sd1686629713;
  localparam longint CENTIDEG    = 64'sd5730;

  // Arctangent of 2^-i in radians, Q30, truncated.
  localparam longint ATAN_TABLE [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef logic signed [tilt_pkg::ACCEL_W-1:0] axis_t;

  typedef struct packed {
    logic signed [tilt_pkg::ROLL_W-1:0]  roll;
    logic signed [tilt_pkg::PITCH_W-1:0] pitch;
  } tilt_angles_t;

  class tilt_scoreboard;
    tilt_angles_t pending_angles[$];
    int           failures;

    function longint unsigned root_q16(longint unsigned radicand);
      longint unsigned root, probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > radicand) probe >>= 2;
      while (probe != 0) begin
        if (radicand >= root + probe) begin
          radicand -= root + probe;
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // Vectoring CORDIC; returns atan2(num, den) in hundredths of a degree.
    function longint atan2_centideg(longint num, longint den);
      longint vx, vy, acc, tmp, dx, dy;
      longint unsigned mag;
      int n_steps;
      if (num == 0 && den == 0) return 0;
      vx  = den;
      vy  = num;
      acc = 0;
      // Rotate the left half-plane by a quarter turn first.
      if (vx < 0) begin
        if (vy >= 0) begin
          tmp = vx; vx = vy; vy = -tmp; acc = HALF_PI_RAD;
        end else begin
          tmp = vx; vx = -vy; vy = tmp; acc = -HALF_PI_RAD;
        end
      end
      while ((vx < 0 ? -vx : vx) < NORM_LIMIT && (vy < 0 ? -vy : vy) < NORM_LIMIT) begin
        vx = vx * 2;
        vy = vy * 2;
      end
      n_steps = (STEPS > 24) ? 24 : STEPS;
      for (int i = 0; i < n_steps; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy > 0) begin
          vx += dx; vy -= dy; acc += ATAN_TABLE[i];
        end else begin
          vx -= dx; vy += dy; acc -= ATAN_TABLE[i];
        end
      end
      mag = (acc < 0) ? -acc : acc;
      mag = (mag * CENTIDEG + (64'd1 << 29)) >> 30;
      return (acc < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function tilt_angles_t tilt_of(logic signed [tilt_pkg::ACCEL_W-1:0] ax,
                                   logic signed [tilt_pkg::ACCEL_W-1:0] ay,
                                   logic signed [tilt_pkg::ACCEL_W-1:0] az);
      longint          x, y, z, roll, pitch;
      longint unsigned sumsq;
      tilt_angles_t    res;
      x = longint'(ax);
      y = longint'(ay);
      z = longint'(az);
      sumsq = y * y + z * z;
      roll  = atan2_centideg(y, z);
      pitch = atan2_centideg(-x * 65536, longint'(root_q16(sumsq << 32)));
      res.roll  = roll[tilt_pkg::ROLL_W-1:0];
      res.pitch = pitch[tilt_pkg::PITCH_W-1:0];
      return res;
    endfunction

    function void note_sample(logic signed [tilt_pkg::ACCEL_W-1:0] ax,
                              logic signed [tilt_pkg::ACCEL_W-1:0] ay,
                              logic signed [tilt_pkg::ACCEL_W-1:0] az);
      pending_angles.push_back(tilt_of(ax, ay, az));
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_angles(logic signed [tilt_pkg::ROLL_W-1:0] roll,
                               logic signed [tilt_pkg::PITCH_W-1:0] pitch);
      tilt_angles_t exp_a;
      if (pending_angles.size() == 0) begin
        report($sformatf("unexpected result roll=%0d pitch=%0d", roll, pitch));
        return;
      end
      exp_a = pending_angles.pop_front();
      if (roll !== exp_a.roll)
        report($sformatf("roll expected %0d actual %0d", exp_a.roll, roll));
      if (pitch !== exp_a.pitch)
        report($sformatf("pitch expected %0d actual %0d", exp_a.pitch, pitch));
    endfunction

    function int outstanding();
      return pending_angles.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  bit   calm = 1'b0;

  tilt_scoreboard tilt_sb = new();

  tilt_sample_if sample_ch ();
  tilt_angle_if  angle_ch ();

  accel_tilt_angles #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .angle  (angle_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready)
      tilt_sb.note_sample(sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z);
    if (!rst && angle_ch.valid && angle_ch.ready)
      tilt_sb.check_angles(angle_ch.roll_centideg, angle_ch.pitch_centideg);
  end

  // Mostly no gap or a short one, now and then a long stall.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(input int ax, input int ay, input int az);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_x <= axis_t'(ax);
    sample_ch.accel_y <= axis_t'(ay);
    sample_ch.accel_z <= axis_t'(az);
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic wait_all_angles();
    sample_ch.valid <= 1'b0;
    // Waiting on the clock lets the monitor record the last accepted request first.
    @(posedge clk);
    while (tilt_sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return int'(axis_t'($urandom));
    if (r < 70) return int'($urandom_range(0, 40000)) - 20000;
    if (r < 85) return int'($urandom_range(0, 16)) - 8;
    if (r < 92) return 0;
    if (r < 96) return -32768;
    return 32767;
  endfunction

  // Result side: ready high for a random run, then an occasional stall.
  initial begin
    int run, gap;
    angle_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      angle_ch.ready <= 1'b1;
      run = calm ? 50 : $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        angle_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int ax, ay, az;
    sample_ch.valid   <= 1'b0;
    sample_ch.accel_x <= '0;
    sample_ch.accel_y <= '0;
    sample_ch.accel_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: null vector, upside down, pure x, full scale.
    send_sample(0, 0, 0);
    send_sample(0, 0, 16384);
    send_sample(0, 0, -16384);
    send_sample(0, 0, -1);
    send_sample(100, 0, 0);
    send_sample(-100, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(32767, 0, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(0, -32768, 0);
    send_sample(0, 32767, 0);
    send_sample(0, -1, -32768);
    send_sample(0, 1, -32768);
    send_sample(-32768, 32767, -32768);
    send_sample(16384, -16384, 1);
    send_sample(1, 1, 1);
    send_sample(-1, -1, -1);
    send_sample(0, 32767, -32768);
    send_sample(12345, -23456, -30000);
    send_sample(-32768, 0, -32768);
    send_sample(32767, -32768, 0);
    wait_all_angles();

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = ((i / 100) % 3) == 1;
      if (i == N_RANDOM / 2) wait_all_angles();
      ax = pick_axis();
      ay = pick_axis();
      az = pick_axis();
      send_sample(ax, ay, az);
    end
    calm = 1'b0;
    wait_all_angles();
    repeat (DRAIN) @(posedge clk);

    if (tilt_sb.outstanding() != 0)
      tilt_sb.report($sformatf("%0d results never arrived", tilt_sb.outstanding()));
    if (tilt_sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/tilt_pkg.sv
hdl/tilt_sample_if.sv
hdl/tilt_angle_if.sv
hdl/tilt_sqrt.sv
hdl/tilt_atan2.sv
hdl/accel_tilt_angles.sv
hdl/tilt_checker.sv
test/tb_accel_tilt_angles.sv
